@@ rtl/trp_pkg.sv @@
package trp_pkg;

	// Coordinate and torus size widths.
	localparam int unsigned COORD_W = 8;
	localparam int unsigned SIZE_W  = 9;

	// Number of route codes packed into one table word.
	localparam int unsigned LANES  = 8;
	localparam int unsigned CODE_W = 3;

	// Link codes of one route entry.
	typedef enum logic [CODE_W-1:0] {
		ROUTE_E    = 3'd0,
		ROUTE_NE   = 3'd1,
		ROUTE_N    = 3'd2,
		ROUTE_W    = 3'd3,
		ROUTE_SW   = 3'd4,
		ROUTE_S    = 3'd5,
		ROUTE_MON  = 3'd6,
		ROUTE_DROP = 3'd7
	} route_t;

	// Status of one own-position reduction unit.
	typedef struct packed {
		logic               busy;
		logic [COORD_W-1:0] rem;
	} own_t;

endpackage

@@ rtl/trp_own_reduce.sv @@
// Reduces one own coordinate modulo the torus size, one quotient bit per cycle.
// A start pulse restarts the reduction; the result is valid while busy is low.
module trp_own_reduce (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [trp_pkg::COORD_W-1:0]    value,
	input  logic [trp_pkg::SIZE_W-1:0]     size,
	output trp_pkg::own_t                  own
);

	localparam int unsigned BIT_W = $clog2(trp_pkg::COORD_W);

	logic [trp_pkg::SIZE_W-1:0] rem_q;
	logic [BIT_W-1:0]           bit_q;
	logic                       busy_q;
	logic [trp_pkg::SIZE_W:0]   trial;
	logic [trp_pkg::SIZE_W:0]   size_ext;

	// Shift in the next dividend bit and try one subtraction.
	assign trial    = {rem_q, value[bit_q]};
	assign size_ext = {1'b0, size};

	// Restoring remainder sequencer, most significant bit first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			bit_q  <= BIT_W'(trp_pkg::COORD_W - 1);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (trial >= size_ext) begin
				rem_q <= trp_pkg::SIZE_W'(trial - size_ext);
			end else begin
				rem_q <= trial[trp_pkg::SIZE_W-1:0];
			end
			if (bit_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	assign own.busy = busy_q;
	assign own.rem  = rem_q[trp_pkg::COORD_W-1:0];

endmodule

@@ rtl/torus_p2p_route_table_gen.sv @@
// Channel   Direction  Handshake           Payload
// in        to block   in_valid/in_stall   word_index
// out       from block out_valid/out_stall route_word, word_index_out
// config    to block   wr_en               wr_index, wr_data
//
// One word is accepted per cycle while in_stall is low; three pipeline stages, the last
// one the output register, carry each word from the input to the output.
// Every configuration write stalls the input while the own position is reduced modulo
// the torus size one bit a cycle; the reset position needs none.
// Each stage holds its item while the next one is full and stalled, so the input
// keeps taking items into empty stages while a result waits at the output.
module torus_p2p_route_table_gen #(
	parameter int unsigned TABLE_WORDS = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [8:0]  wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [12:0] word_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] word_index_out,
	output logic [23:0] route_word
);

	localparam int unsigned LANES  = trp_pkg::LANES;
	localparam int unsigned CODE_W = trp_pkg::CODE_W;
	localparam int unsigned CW     = trp_pkg::COORD_W;
	localparam int unsigned SW     = trp_pkg::SIZE_W;

	typedef enum logic [1:0] {
		REG_MY_X   = 2'd0,
		REG_MY_Y   = 2'd1,
		REG_SIZE_X = 2'd2,
		REG_SIZE_Y = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_STAY  = 2'd0,
		DIR_PLUS  = 2'd1,
		DIR_MINUS = 2'd2
	} dir_t;

	// First-stage compare results of one axis.
	typedef struct packed {
		logic          out;
		logic          stay;
		logic          ge;
		logic [SW-1:0] raw;
	} axis_t;

	// Compares a destination coordinate with the own coordinate and the size.
	function automatic axis_t axis_pre(input logic [CW-1:0] dest, input logic [CW-1:0] own,
			input logic [SW-1:0] size);
		axis_t a;
		a.out  = {1'b0, dest} >= size;
		a.stay = dest == own;
		a.ge   = dest >= own;
		a.raw  = {1'b0, dest} - {1'b0, own};
		return a;
	endfunction

	// Wraps the distance onto the torus and picks the direction of one axis.
	function automatic dir_t axis_dir(input axis_t a, input logic [SW-1:0] size);
		logic [SW-1:0] diff;
		dir_t          d;
		diff = a.ge ? a.raw : a.raw + size;
		if (a.stay) begin
			d = DIR_STAY;
		end else if (diff <= {1'b0, size[SW-1:1]}) begin
			d = DIR_PLUS;
		end else begin
			d = DIR_MINUS;
		end
		return d;
	endfunction

	// Merges the two axis decisions into one link; diagonals without a link
	// split on the parity of the destination id.
	function automatic trp_pkg::route_t merge(input dir_t vx, input dir_t vy, input logic odd);
		trp_pkg::route_t r;
		r = trp_pkg::ROUTE_DROP;
		case (vx)
			DIR_STAY: begin
				case (vy)
					DIR_STAY:  r = trp_pkg::ROUTE_MON;
					DIR_PLUS:  r = trp_pkg::ROUTE_N;
					default:   r = trp_pkg::ROUTE_S;
				endcase
			end
			DIR_MINUS: begin
				case (vy)
					DIR_STAY:  r = trp_pkg::ROUTE_W;
					DIR_PLUS:  r = odd ? trp_pkg::ROUTE_N : trp_pkg::ROUTE_W;
					default:   r = trp_pkg::ROUTE_SW;
				endcase
			end
			default: begin
				case (vy)
					DIR_STAY:  r = trp_pkg::ROUTE_E;
					DIR_PLUS:  r = trp_pkg::ROUTE_NE;
					default:   r = odd ? trp_pkg::ROUTE_S : trp_pkg::ROUTE_E;
				endcase
			end
		endcase
		return r;
	endfunction

	logic [CW-1:0] my_x_q, my_y_q;
	logic [SW-1:0] size_x_q, size_y_q;
	trp_pkg::own_t own_x, own_y;

	logic take, adv1, adv2, adv3;

	logic          v_s1, v_s2, v_s3;
	logic [12:0]   idx_s1, idx_s2, idx_s3;
	logic          inr_s1, inr_s2;
	axis_t         ax_s1;
	axis_t         ay_s1 [LANES];
	logic          xout_s2;
	dir_t          dx_s2;
	logic          yout_s2 [LANES];
	dir_t          dy_s2 [LANES];
	logic [LANES*CODE_W-1:0] word_s3;

	axis_t                   ax_d;
	axis_t                   ay_d [LANES];
	logic [LANES*CODE_W-1:0] word_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_x_q   <= '0;
			my_y_q   <= '0;
			size_x_q <= SW'(1);
			size_y_q <= SW'(1);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_MY_X:   my_x_q   <= wr_data[CW-1:0];
				REG_MY_Y:   my_y_q   <= wr_data[CW-1:0];
				REG_SIZE_X: size_x_q <= wr_data;
				REG_SIZE_Y: size_y_q <= wr_data;
				default:    ;
			endcase
		end
	end

	// Own position reduced onto the torus, one unit per axis.
	trp_own_reduce u_red_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wr_en),
		.value  (my_x_q),
		.size   (size_x_q),
		.own    (own_x)
	);

	trp_own_reduce u_red_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wr_en),
		.value  (my_y_q),
		.size   (size_y_q),
		.own    (own_y)
	);

	// Stage advance: a stage moves on when its successor is empty or moving.
	assign adv3     = !v_s3 || !out_stall;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1 || own_x.busy || own_y.busy;
	assign take     = in_valid && !in_stall;

	// Stage 1 compares: x is shared by the word, y differs in each lane.
	always_comb begin
		ax_d = axis_pre(word_index[12:5], own_x.rem, size_x_q);
		for (int j = 0; j < LANES; j++) begin
			ay_d[j] = axis_pre({word_index[4:0], 3'(j)}, own_y.rem, size_y_q);
		end
	end

	// Stage 3 merge of both axes into the packed word.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			if (!inr_s2 || xout_s2 || yout_s2[j]) begin
				word_d[j*CODE_W +: CODE_W] = trp_pkg::ROUTE_DROP;
			end else begin
				word_d[j*CODE_W +: CODE_W] = merge(dx_s2, dy_s2[j], 1'(j % 2));
			end
		end
	end

	// Valid bits travel with their stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= take;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (adv1) begin
			idx_s1 <= word_index;
			inr_s1 <= {1'b0, word_index} < 14'(TABLE_WORDS);
			ax_s1  <= ax_d;
			for (int j = 0; j < LANES; j++) begin
				ay_s1[j] <= ay_d[j];
			end
		end
		if (adv2) begin
			idx_s2  <= idx_s1;
			inr_s2  <= inr_s1;
			xout_s2 <= ax_s1.out;
			dx_s2   <= axis_dir(ax_s1, size_x_q);
			for (int j = 0; j < LANES; j++) begin
				yout_s2[j] <= ay_s1[j].out;
				dy_s2[j]   <= axis_dir(ay_s1[j], size_y_q);
			end
		end
		if (adv3) begin
			idx_s3  <= idx_s2;
			word_s3 <= word_d;
		end
	end

	assign out_valid      = v_s3;
	assign word_index_out = idx_s3;
	assign route_word     = word_s3;

endmodule

@@ rtl/trp_checker.sv @@
// Port-level checks of the route table generator.
module trp_checker #(
	parameter int unsigned TABLE_WORDS = 8192
) (
	input logic        clk,
	input logic        arst_n,
	input logic        wr_en,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [12:0] word_index_out,
	input logic [23:0] route_word
);

	logic [trp_pkg::LANES-1:0] mon_lanes;

	// Lanes that point at this chip.
	always_comb begin
		for (int j = 0; j < trp_pkg::LANES; j++) begin
			mon_lanes[j] = route_word[j*trp_pkg::CODE_W +: trp_pkg::CODE_W] == trp_pkg::ROUTE_MON;
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_index_out) && $stable(route_word))
		else $error("stalled result changed");

	// A configuration write blocks input while the position is reduced.
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> in_stall)
		else $error("input not stalled after configuration write");

	// A word beyond the table routes every lane to drop.
	a_beyond: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ({1'b0, word_index_out} >= 14'(TABLE_WORDS)) |-> route_word == '1)
		else $error("word beyond table not all drop");

	// Only one destination id of a word can be this chip.
	a_one_mon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(mon_lanes) <= 1)
		else $error("more than one monitor lane in a word");

endmodule

bind torus_p2p_route_table_gen trp_checker #(.TABLE_WORDS(TABLE_WORDS)) u_trp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.wr_en          (wr_en),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.word_index_out (word_index_out),
	.route_word     (route_word)
);
